### rtl/core/swm_pkg.sv
package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 7;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;
  localparam int MAX_WINDOW_DEF = 64;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_SIZE = 1'b0;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(1);

  // what a cell shows its neighbours
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     vld;
    logic                     gt;   // empty, or above the incoming word
    logic                     ge;   // valid and at or above the leaving word
  } swm_link_t;

  // broadcast to every cell
  typedef struct packed {
    logic signed [DATA_W-1:0] smp;
    logic signed [DATA_W-1:0] old;
    logic                     del;
    logic                     upd;
    logic                     clr;
    logic                     adv;
  } swm_bcast_t;

  // one stage of the median relay line
  typedef struct packed {
    logic signed [DATA_W-1:0] d;
    logic                     v;
  } swm_relay_t;

  localparam swm_link_t LINK_EDGE_L = '{val: '0, vld: 1'b0, gt: 1'b0, ge: 1'b0};
  localparam swm_link_t LINK_EDGE_R = '{val: '0, vld: 1'b0, gt: 1'b1, ge: 1'b0};
  localparam swm_relay_t RELAY_EDGE = '{d: '0, v: 1'b0};

endpackage

### rtl/core/swm_if.sv
interface swm_sample_if;
  import swm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if;
  import swm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

### rtl/core/swm_hist.sv
module swm_hist #(
  parameter int DEPTH = swm_pkg::MAX_WINDOW_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [IW-1:0]                    waddr_i,
  input  logic signed [swm_pkg::DATA_W-1:0] wdata_i,
  input  logic [IW-1:0]                    raddr_i,
  output logic signed [swm_pkg::DATA_W-1:0] rdata_o
);
  import swm_pkg::*;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/swm_cell.sv
module swm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swm_pkg::swm_bcast_t bcast_i,
  input  swm_pkg::swm_link_t  left_i,
  input  swm_pkg::swm_link_t  right_i,
  output swm_pkg::swm_link_t  link_o,
  input  logic                load_i,
  input  swm_pkg::swm_relay_t relay_i,
  output swm_pkg::swm_relay_t relay_o
);
  import swm_pkg::*;

  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     vld_q, vld_d;
  logic signed [DATA_W-1:0] rel_val_q;
  logic                     rel_vld_q;
  swm_relay_t               rel_d;

  logic                     own_gt, own_ge, del_own, del_left;
  logic signed [DATA_W-1:0] b_val, bl_val;
  logic                     b_vld, bl_vld, b_gt, bl_gt;

  // compare against the incoming and the leaving word
  assign own_gt = !vld_q || (val_q > bcast_i.smp);
  assign own_ge = vld_q && (val_q >= bcast_i.old);

  assign link_o = '{val: val_q, vld: vld_q, gt: own_gt, ge: own_ge};

  assign del_own  = bcast_i.del && own_ge;
  assign del_left = bcast_i.del && left_i.ge;

  // row after the leaving word is dropped, here and one place to the left
  always_comb begin
    b_val  = del_own ? right_i.val : val_q;
    b_vld  = del_own ? right_i.vld : vld_q;
    b_gt   = del_own ? right_i.gt  : own_gt;
    bl_val = del_left ? val_q  : left_i.val;
    bl_vld = del_left ? vld_q  : left_i.vld;
    bl_gt  = del_left ? own_gt : left_i.gt;
  end

  // then open a gap for the new word
  always_comb begin
    if (bl_gt) begin
      val_d = bl_val;
      vld_d = bl_vld;
    end else if (b_gt) begin
      val_d = bcast_i.smp;
      vld_d = 1'b1;
    end else begin
      val_d = b_val;
      vld_d = b_vld;
    end
  end

  always_comb begin
    rel_d = relay_i;
    if (load_i) begin
      rel_d = '{d: val_d, v: 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (bcast_i.upd) begin
      val_q <= val_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (bcast_i.clr) begin
      vld_q <= 1'b0;
    end else if (bcast_i.upd) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bcast_i.adv) begin
      rel_val_q <= rel_d.d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_vld_q <= 1'b0;
    end else if (bcast_i.clr) begin
      rel_vld_q <= 1'b0;
    end else if (bcast_i.adv) begin
      rel_vld_q <= rel_d.v;
    end
  end

  assign relay_o = '{d: rel_val_q, v: rel_vld_q};

endmodule

### rtl/core/sliding_window_median_unit.sv
// Running median over a stream of signed 32-bit words.
// sample_i takes one word per handshake; median_o gives one word per
// handshake once the window holds window_size words: the lower median,
// rank ceil(window_size/2) from the smallest, duplicates counted. No word
// comes out while the window is still filling.
// The APB port holds window_size at byte address 0 (zero acts as 1, values
// above MAX_WINDOW act as MAX_WINDOW). A write empties the window.
// After a sample is taken, sample_i is not ready while the history memory
// port fetches the word that the next sample pushes out. The median leaves
// the sorted row at the cell of its rank k = (size-1)/2 and walks down a
// relay line to the output register.
// Reset empties the window and sets window_size to 1.
// When median_o stalls, the relay line and output register hold and
// sample_i is not ready until the output word has been taken.
module sliding_window_median_unit #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  swm_sample_if.sink                         sample_i,
  swm_median_if.source                       median_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [swm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [swm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import swm_pkg::*;

  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int WW = (CW > CFG_W) ? CW : CFG_W;

  // configuration register
  logic [CFG_W-1:0] ws_q, ws_d;
  logic             cfg_wr;

  // window bookkeeping
  logic [CW-1:0] fill_q, fill_d, fill_inc, eff_size;
  logic [IW-1:0] wp_q, wp_d, rp_q, rp_d, rank_idx;
  logic          busy_q, busy_d;
  logic          fire, full, emit, adv;
  logic [WW-1:0] ws_ext;

  // output register
  logic                     out_v_q, out_v_d;
  logic signed [DATA_W-1:0] out_d_q, out_d_d;

  logic signed [DATA_W-1:0] old_smp;
  swm_bcast_t               bcast;
  swm_link_t                link  [MAX_WINDOW];
  swm_relay_t               relay [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]    vld_vec;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    return (p == IW'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
  endfunction

  // APB: always ready, one register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? APB_DATA_W'(ws_q) : '0;
  assign ws_d   = cfg_wr ? pwdata[CFG_W-1:0] : ws_q;

  // clamp the size to one .. MAX_WINDOW
  assign ws_ext = WW'(ws_q);
  always_comb begin
    if (ws_q == '0) begin
      eff_size = CW'(1);
    end else if (ws_ext > WW'(MAX_WINDOW)) begin
      eff_size = CW'(MAX_WINDOW);
    end else begin
      eff_size = CW'(ws_ext);
    end
  end

  assign rank_idx = IW'((eff_size - 1'b1) >> 1);

  // hold input while the history read is under way or the relay is frozen
  assign adv             = !out_v_q || median_o.ready;
  assign sample_i.ready  = !busy_q && adv;
  assign fire            = sample_i.valid && sample_i.ready;
  assign full            = (fill_q == eff_size);
  assign fill_inc        = fill_q + 1'b1;
  assign emit            = fire && (full || (fill_inc == eff_size));

  always_comb begin
    fill_d = fill_q;
    wp_d   = wp_q;
    rp_d   = rp_q;
    busy_d = fire;
    if (cfg_wr) begin
      fill_d = '0;
      wp_d   = '0;
      rp_d   = '0;
    end else if (fire) begin
      wp_d = ptr_inc(wp_q);
      if (full) begin
        // drop the oldest word, fill stays
        rp_d = ptr_inc(rp_q);
      end else begin
        fill_d = fill_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= WINDOW_SIZE_RST;
      fill_q <= '0;
      wp_q   <= '0;
      rp_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      ws_q   <= ws_d;
      fill_q <= fill_d;
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      busy_q <= busy_d;
    end
  end

  // history of samples in arrival order; rp_q points at the oldest
  swm_hist #(
    .DEPTH (MAX_WINDOW),
    .IW    (IW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (wp_q),
    .wdata_i (sample_i.sample),
    .raddr_i (rp_q),
    .rdata_o (old_smp)
  );

  assign bcast = '{smp: sample_i.sample, old: old_smp, del: full,
                   upd: fire, clr: cfg_wr, adv: adv};

  // sorted row, smallest at cell 0; relay line runs towards cell 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_link_t  left_l, right_l;
    swm_relay_t relay_r;

    if (i == 0) begin : g_l_edge
      assign left_l = LINK_EDGE_L;
    end else begin : g_l_mid
      assign left_l = link[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_r_edge
      assign right_l = LINK_EDGE_R;
      assign relay_r = RELAY_EDGE;
    end else begin : g_r_mid
      assign right_l = link[i+1];
      assign relay_r = relay[i+1];
    end

    swm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bcast_i (bcast),
      .left_i  (left_l),
      .right_i (right_l),
      .link_o  (link[i]),
      .load_i  (emit && (rank_idx == IW'(i))),
      .relay_i (relay_r),
      .relay_o (relay[i])
    );

    assign vld_vec[i] = link[i].vld;
  end

  // output register fed from the foot of the relay line
  always_comb begin
    out_v_d = out_v_q;
    out_d_d = out_d_q;
    if (cfg_wr) begin
      out_v_d = 1'b0;
    end else if (adv) begin
      out_v_d = relay[0].v;
      out_d_d = relay[0].d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_d_q <= out_d_d;
  end

  assign median_o.valid  = out_v_q;
  assign median_o.median = out_d_q;

`ifndef SYNTHESIS
  // the history read takes the cycle after every sample, so no sample is taken then
  a_busy_after_fire : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> !sample_i.ready)
    else $error("sample taken during history read");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= eff_size)
    else $error("fill count beyond window size");

  a_row_matches_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) == int'(fill_q))
    else $error("occupied cells disagree with fill count");

  a_row_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) |-> link[0].vld)
    else $error("sorted row not packed at its low end");
`endif

endmodule

### tb/tb_sliding_window_median_unit.sv
`timescale 1ns / 1ps

module tb_sliding_window_median_unit;
  import swm_pkg::*;

  localparam int          MAX_WIN      = MAX_WINDOW_DEF;
  localparam int unsigned RANDOM_WORDS = 1450;
  // room for the longest relay walk, from rank (MAX_WIN-1)/2, with a margin on top
  localparam int unsigned SETTLE       = 48;
  localparam int unsigned QUIET_LIMIT  = 2000;

  localparam logic [APB_ADDR_W-1:0] WINDOW_SIZE_ADDR = {REG_WINDOW_SIZE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR       = {~REG_WINDOW_SIZE, 2'b00};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  swm_sample_if smp_if ();
  swm_median_if med_if ();

  sliding_window_median_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .median_o (med_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // words waiting to be offered on the sample channel, filled by the stimulus block
  logic signed [DATA_W-1:0] pending_samples[$];
  // medians the window predicts, oldest first
  logic signed [DATA_W-1:0] expected_medians[$];

  // predictor state: window contents in arrival order (oldest at the front)
  logic signed [DATA_W-1:0] window_hist[$];
  logic [CFG_W-1:0]         window_size_reg;

  int unsigned mismatches = 0;
  int unsigned src_gap    = 0;
  int unsigned src_calm   = 0;
  int unsigned snk_gap    = 0;
  int unsigned snk_calm   = 0;
  int unsigned quiet      = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Append a word to the tail of the pending queue.
  task automatic queue_word(input logic signed [DATA_W-1:0] w);
    pending_samples = {pending_samples, w};
  endtask

  // Idle length for either side of the stream: mostly none or short, now and then long.
  // A calm stretch forces a run of back-to-back words.
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Clamp the register to the span the block really uses: zero acts as one,
  // anything above the array size acts as the array size.
  function automatic int unsigned window_span(input logic [CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > MAX_WIN) return MAX_WIN;
    return int'(raw);
  endfunction

  // Slide one word into the window; return 1 with the lower median once the
  // window holds exactly its span of words.
  function automatic bit slide_window(input logic signed [DATA_W-1:0] smp,
                                      output logic signed [DATA_W-1:0] med);
    int unsigned span;
    int unsigned rank;
    int unsigned below;
    int unsigned at_or_below;
    span = window_span(window_size_reg);
    med  = '0;
    // drop the oldest words until the new one fits
    while (window_hist.size() >= span) void'(window_hist.pop_front());
    window_hist = {window_hist, smp};
    if (window_hist.size() != span) return 1'b0;
    rank = (span + 1) / 2;
    // the median is the word whose rank range, duplicates counted, covers rank
    foreach (window_hist[i]) begin
      below       = 0;
      at_or_below = 0;
      foreach (window_hist[j]) begin
        if (window_hist[j] < window_hist[i]) below++;
        if (window_hist[j] <= window_hist[i]) at_or_below++;
      end
      if (below < rank && at_or_below >= rank) med = window_hist[i];
    end
    return 1'b1;
  endfunction

  // Mix of full-range words, a narrow band that breeds duplicates, and the
  // extremes of the signed range with their neighbours.
  function automatic logic signed [DATA_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom;
    if (r < 80) return $urandom_range(0, 16) - 32'd8;
    if (r < 90) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if ($urandom_range(0, 1) == 1) return 32'h7FFF_FFF0 + $urandom_range(0, 15);
    return 32'h8000_0000 + $urandom_range(0, 15);
  endfunction

  // Sample driver: offer the next pending word, hold it under back-pressure,
  // and run the predictor on every accepted word.
  always @(posedge clk_i) begin : drive_samples
    logic signed [DATA_W-1:0] med;
    bit                       has_med;
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        has_med = slide_window(smp_if.sample, med);
        if (has_med) expected_medians = {expected_medians, med};
      end
      // hold the current word until the block takes it
      if (!(smp_if.valid && !smp_if.ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          smp_if.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          smp_if.valid  <= 1'b1;
          smp_if.sample <= pending_samples.pop_front();
          src_gap = idle_len(src_calm);
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  // Median monitor: compare every accepted word with the oldest prediction,
  // and stall the output at random.
  always @(posedge clk_i) begin : collect_medians
    logic signed [DATA_W-1:0] want;
    if (!rst_ni) begin
      med_if.ready <= 1'b0;
    end else begin
      if (med_if.valid && med_if.ready) begin
        if (expected_medians.size() == 0) begin
          report_mismatch($sformatf("median %0d arrived with none expected", med_if.median));
        end else begin
          want = expected_medians.pop_front();
          if (med_if.median !== want)
            report_mismatch($sformatf("median %0d, expected %0d (window_size %0d)",
                                      med_if.median, want, window_size_reg));
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        med_if.ready <= 1'b0;
      end else begin
        med_if.ready <= 1'b1;
        snk_gap = idle_len(snk_calm);
      end
    end
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((smp_if.valid && smp_if.ready) || (med_if.valid && med_if.ready) ||
          (psel && penable)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("tb_sliding_window_median_unit NOT OK");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Sample prdata at the edge that closes the access phase (pready is always high).
  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                          output logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_window_size_reg();
    logic [APB_DATA_W-1:0] rd;
    apb_read(WINDOW_SIZE_ADDR, rd);
    if (rd !== APB_DATA_W'(window_size_reg))
      report_mismatch($sformatf("window_size reads 0x%0h, expected 0x%0h", rd, window_size_reg));
  endtask

  // Block until every word has been taken and every median has come out.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || smp_if.valid || expected_medians.size() != 0);
  endtask

  // Drain, let the sorted row settle (filling words give no median to wait on),
  // then write window_size with junk in the upper bits and read it back.
  task automatic set_window_size(input logic [CFG_W-1:0] raw);
    logic [APB_DATA_W-1:0] junk;
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    junk = $urandom;
    apb_write(WINDOW_SIZE_ADDR, {junk[APB_DATA_W-1:CFG_W], raw});
    window_size_reg = raw;
    window_hist.delete();
    check_window_size_reg();
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0]         raw;
    logic [CFG_W-1:0]         forced_sizes[3];
    logic [APB_DATA_W-1:0]    junk;
    int unsigned              span;
    int unsigned              count;
    int unsigned              queued;
    int unsigned              phase;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    window_size_reg = WINDOW_SIZE_RST;
    forced_sizes    = '{7'd127, 7'd64, 7'd65};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset value first: a window of one echoes every word
    check_window_size_reg();
    queue_word(32'h8000_0000);
    queue_word(32'h7FFF_FFFF);
    queue_word(32'h0000_0000);
    queue_word(32'hFFFF_FFFF);
    queue_word(32'h0000_0001);

    // odd window: duplicates, then both ends of the signed range
    set_window_size(7'd3);
    queue_word(32'sd5);
    queue_word(32'sd5);
    queue_word(32'sd5);
    queue_word(32'h8000_0000);
    queue_word(32'h7FFF_FFFF);
    queue_word(32'h0000_0000);
    queue_word(32'sd7);
    queue_word(-32'sd7);

    // size zero behaves as one
    set_window_size(7'd0);
    queue_word(32'hAAAA_AAAA);
    queue_word(32'h5555_5555);
    queue_word(32'sd42);

    // even window: the lower median is the smaller of the pair
    set_window_size(7'd2);
    queue_word(32'hFFFF_FFFF);
    queue_word(32'h7FFF_FFFF);
    queue_word(32'h8000_0000);
    queue_word(32'h8000_0000);

    // a write to an unmapped address must neither change the size nor empty the window
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    junk = $urandom;
    apb_write(SPARE_ADDR, junk);
    check_window_size_reg();
    queue_word(32'sd9);
    queue_word(-32'sd9);
    queue_word(32'sd3);

    // random phases: the largest sizes first, then mostly small windows
    queued = 0;
    phase  = 0;
    while (queued < RANDOM_WORDS) begin
      if (phase < 3) begin
        raw = forced_sizes[phase];
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: raw = CFG_W'($urandom_range(13, 63));
          3, 4:    raw = CFG_W'($urandom_range(64, 127));
          5:       raw = 7'd0;
          default: raw = CFG_W'($urandom_range(1, 12));
        endcase
      end
      span = window_span(raw);
      // now and then queue no more than the span, so the next write may empty a partial window
      if ($urandom_range(0, 9) == 0) count = $urandom_range(1, span);
      else count = span + $urandom_range(0, 40);
      set_window_size(raw);
      repeat (count) queue_word(pick_sample());
      queued += count;
      phase++;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_sliding_window_median_unit OK");
    end else begin
      $display("tb_sliding_window_median_unit NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/swm_pkg.sv
rtl/core/swm_if.sv
rtl/core/swm_hist.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_median_unit.sv
tb/tb_sliding_window_median_unit.sv
